// ===== rtl/core/blps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the lamp pattern sequencer.
// No dependencies; every other file in rtl/core imports this package.
package blps_pkg;

    localparam int PATTERN_STEPS = 9;
    localparam int PATTERN_SLOTS = 4;
    localparam int SLOT_W        = $clog2(PATTERN_SLOTS);
    localparam int IDX_W         = 4;
    localparam int STEPS_W       = 18;
    localparam int SEL_W         = $clog2(STEPS_W);
    localparam int TIME_W        = 32;
    localparam int PERIOD_W      = 16;
    localparam int MODE_W        = 3;
    localparam int BLINK_MODES   = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int IN_DATA_W     = 32;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 8;

    // Lamp vector: red in bit 2, yellow in bit 1, green in bit 0.
    localparam logic [2:0] LAMP_OFF = 3'b000;
    localparam logic [2:0] LAMP_R   = 3'b100;
    localparam logic [2:0] LAMP_Y   = 3'b010;
    localparam logic [2:0] LAMP_G   = 3'b001;

    // Two-phase blink patterns of modes 1..3, phase 1 and phase 0.
    localparam logic [2:0] BLINK_ON1 [BLINK_MODES] = '{LAMP_Y, LAMP_Y | LAMP_G, LAMP_Y | LAMP_G};
    localparam logic [2:0] BLINK_ON0 [BLINK_MODES] = '{LAMP_R | LAMP_G, LAMP_R | LAMP_G, LAMP_R};

    localparam logic [MODE_W-1:0] MODE_FIXED      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LAST_BLINK = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIRST_SLOT = 3'd4;

    localparam logic [1:0] STEP_DARK   = 2'd0;
    localparam logic [1:0] STEP_GREEN  = 2'd1;
    localparam logic [1:0] STEP_YELLOW = 2'd2;
    localparam logic [1:0] STEP_RED    = 2'd3;

    localparam logic [PERIOD_W-1:0] DEBOUNCE_RST     = 16'd10;
    localparam logic [PERIOD_W-1:0] BLINK_ONE_RST    = 16'd50;
    localparam logic [PERIOD_W-1:0] BLINK_TWO_RST    = 16'd200;
    localparam logic [PERIOD_W-1:0] BLINK_THREE_RST  = 16'd800;
    localparam logic [PERIOD_W-1:0] STEP_LOW_RST     = 16'd200;
    localparam logic [PERIOD_W-1:0] STEP_MEDIUM_RST  = 16'd600;
    localparam logic [PERIOD_W-1:0] STEP_HIGH_RST    = 16'd1000;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_SET     = 2'd1,
        KIND_PROGRAM = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DELAY_LOW    = 2'd0,
        DELAY_MEDIUM = 2'd1,
        DELAY_HIGH   = 2'd2
    } delay_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_BLINK_ONE    = 3'd1,
        REG_BLINK_TWO    = 3'd2,
        REG_BLINK_THREE  = 3'd3,
        REG_STEP_LOW     = 3'd4,
        REG_STEP_MEDIUM  = 3'd5,
        REG_STEP_HIGH    = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] debounce_ms;
        logic [PERIOD_W-1:0] blink_period_one;
        logic [PERIOD_W-1:0] blink_period_two;
        logic [PERIOD_W-1:0] blink_period_three;
        logic [PERIOD_W-1:0] step_period_low;
        logic [PERIOD_W-1:0] step_period_medium;
        logic [PERIOD_W-1:0] step_period_high;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               button_level;
        logic [MODE_W-1:0]  new_mode;
        logic [STEPS_W-1:0] pattern_steps;
        logic [IDX_W-1:0]   pattern_length;
        logic [1:0]         delay_choice;
    } item_t;

    typedef struct packed {
        logic [2:0]        lamps;
        logic [MODE_W-1:0] mode;
    } result_t;

    // True when more than period ticks have passed since last, modulo 2^32.
    function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] last,
                                     input logic [PERIOD_W-1:0] period);
        logic [TIME_W-1:0] diff;
        diff = now - last;
        return diff > {{(TIME_W-PERIOD_W){1'b0}}, period};
    endfunction

    // a mod len for small a (at most PATTERN_STEPS) and len >= 1:
    // keep the largest multiple of len that fits, checked in parallel.
    function automatic logic [IDX_W-1:0] step_wrap(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] len);
        logic [2*IDX_W-1:0] prod;
        logic [IDX_W-1:0]   res;
        res = a;
        for (int q = 0; q <= PATTERN_STEPS; q++) begin
            prod = (2*IDX_W)'(q) * {{IDX_W{1'b0}}, len};
            if (prod <= {{IDX_W{1'b0}}, a}) begin
                res = IDX_W'({{IDX_W{1'b0}}, a} - prod);
            end
        end
        return res;
    endfunction

    function automatic logic [2:0] code_to_lamps(input logic [1:0] code);
        logic [2:0] l;
        case (code)
            STEP_GREEN:  l = LAMP_G;
            STEP_YELLOW: l = LAMP_Y;
            STEP_RED:    l = LAMP_R;
            default:     l = LAMP_OFF;
        endcase
        return l;
    endfunction

endpackage

// ===== rtl/core/blps_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file: debounce delay, blink periods, step periods.
// Depends on blps_pkg.
module blps_cfg_regs
    import blps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [PERIOD_W-1:0]  wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index_t'(wr_index))
                REG_DEBOUNCE:    cfg_next.debounce_ms        = wr_data;
                REG_BLINK_ONE:   cfg_next.blink_period_one   = wr_data;
                REG_BLINK_TWO:   cfg_next.blink_period_two   = wr_data;
                REG_BLINK_THREE: cfg_next.blink_period_three = wr_data;
                REG_STEP_LOW:    cfg_next.step_period_low    = wr_data;
                REG_STEP_MEDIUM: cfg_next.step_period_medium = wr_data;
                REG_STEP_HIGH:   cfg_next.step_period_high   = wr_data;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms        <= DEBOUNCE_RST;
            cfg_reg.blink_period_one   <= BLINK_ONE_RST;
            cfg_reg.blink_period_two   <= BLINK_TWO_RST;
            cfg_reg.blink_period_three <= BLINK_THREE_RST;
            cfg_reg.step_period_low    <= STEP_LOW_RST;
            cfg_reg.step_period_medium <= STEP_MEDIUM_RST;
            cfg_reg.step_period_high   <= STEP_HIGH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/blps_core.sv =====
`timescale 1ns / 1ps
// Sequencer state and single-pass update: time base, debounce, mode,
// blink phases, pattern slots and step index. Depends on blps_pkg.
module blps_core
    import blps_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [TIME_W-1:0]   time_reg, time_next;
    logic                seen_reg, seen_next;
    logic [TIME_W-1:0]   change_reg, change_next;
    logic                handled_reg, handled_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                phase_reg [BLINK_MODES];
    logic                phase_next [BLINK_MODES];
    logic [TIME_W-1:0]   blink_last_reg [BLINK_MODES];
    logic [TIME_W-1:0]   blink_last_next [BLINK_MODES];
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [TIME_W-1:0]   step_last_reg, step_last_next;
    logic [STEPS_W-1:0]  slot_steps_reg [PATTERN_SLOTS];
    logic [STEPS_W-1:0]  slot_steps_next [PATTERN_SLOTS];
    logic [IDX_W-1:0]    slot_len_reg [PATTERN_SLOTS];
    logic [IDX_W-1:0]    slot_len_next [PATTERN_SLOTS];
    logic [PERIOD_W-1:0] slot_period_reg [PATTERN_SLOTS];
    logic [PERIOD_W-1:0] slot_period_next [PATTERN_SLOTS];
    logic [SLOT_W-1:0]   ptr_reg, ptr_next;
    logic [2:0]          lamps_reg, lamps_next;

    logic [TIME_W-1:0]   time_tick;
    logic [PERIOD_W-1:0] blink_period [BLINK_MODES];
    logic                blink_hit [BLINK_MODES];
    logic                step_hit [PATTERN_SLOTS];

    logic [1:0]          blink_sel;
    logic [MODE_W-1:0]   slot_num;
    logic [SLOT_W-1:0]   slot_sel;
    logic [IDX_W-1:0]    sel_len;
    logic [STEPS_W-1:0]  sel_steps;
    logic [SEL_W-1:0]    bit_pos;
    logic [IDX_W-1:0]    len_sat;
    logic [PERIOD_W-1:0] prog_period;

    assign time_tick       = time_reg + TIME_W'(1);
    assign blink_period[0] = cfg.blink_period_one;
    assign blink_period[1] = cfg.blink_period_two;
    assign blink_period[2] = cfg.blink_period_three;

    // Period checks for every blink mode and slot in parallel; the mode mux picks one.
    always_comb begin
        for (int b = 0; b < BLINK_MODES; b++) begin
            blink_hit[b] = elapsed(time_tick, blink_last_reg[b], blink_period[b]);
        end
        for (int s = 0; s < PATTERN_SLOTS; s++) begin
            step_hit[s] = elapsed(time_tick, step_last_reg, slot_period_reg[s]);
        end
    end

    always_comb begin
        time_next      = time_reg;
        seen_next      = seen_reg;
        change_next    = change_reg;
        handled_next   = handled_reg;
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        blink_last_next = blink_last_reg;
        idx_next       = idx_reg;
        step_last_next = step_last_reg;
        slot_steps_next  = slot_steps_reg;
        slot_len_next    = slot_len_reg;
        slot_period_next = slot_period_reg;
        ptr_next       = ptr_reg;
        lamps_next     = lamps_reg;
        blink_sel      = 2'd0;
        slot_num       = '0;
        slot_sel       = '0;
        sel_len        = '0;
        sel_steps      = '0;
        bit_pos        = '0;
        len_sat        = '0;
        prog_period    = '0;

        case (kind_t'(item.kind))
            KIND_TICK: begin
                time_next = time_tick;
                if (item.button_level != seen_reg) begin
                    seen_next    = item.button_level;
                    change_next  = time_tick;
                    handled_next = 1'b0;
                end else if (item.button_level && !handled_reg &&
                             elapsed(time_tick, change_reg, cfg.debounce_ms)) begin
                    mode_next    = mode_reg + MODE_W'(1);
                    handled_next = 1'b1;
                end

                if (mode_next == MODE_FIXED) begin
                    lamps_next = LAMP_Y | LAMP_G;
                end else if (mode_next <= MODE_LAST_BLINK) begin
                    blink_sel = 2'(mode_next - MODE_W'(1));
                    if (blink_hit[blink_sel]) begin
                        phase_next[blink_sel]      = !phase_reg[blink_sel];
                        blink_last_next[blink_sel] = time_tick;
                    end
                    lamps_next = phase_next[blink_sel] ? BLINK_ON1[blink_sel]
                                                       : BLINK_ON0[blink_sel];
                end else begin
                    lamps_next = LAMP_OFF;
                    slot_num   = mode_next - MODE_FIRST_SLOT;
                    slot_sel   = slot_num[SLOT_W-1:0];
                    if (slot_num < MODE_W'(PATTERN_SLOTS)) begin
                        sel_len   = slot_len_reg[slot_sel];
                        sel_steps = slot_steps_reg[slot_sel];
                        if (sel_len != '0) begin
                            if (step_hit[slot_sel]) begin
                                idx_next       = step_wrap(idx_reg + IDX_W'(1), sel_len);
                                step_last_next = time_tick;
                            end
                            bit_pos = SEL_W'({idx_next, 1'b0});
                            if (idx_next < sel_len && idx_next < IDX_W'(PATTERN_STEPS)) begin
                                lamps_next = code_to_lamps(sel_steps[bit_pos +: 2]);
                            end
                        end
                    end
                end
            end
            KIND_SET: begin
                mode_next = item.new_mode;
            end
            KIND_PROGRAM: begin
                len_sat = (item.pattern_length > IDX_W'(PATTERN_STEPS)) ?
                          IDX_W'(PATTERN_STEPS) : item.pattern_length;
                case (delay_t'(item.delay_choice))
                    DELAY_LOW:    prog_period = cfg.step_period_low;
                    DELAY_MEDIUM: prog_period = cfg.step_period_medium;
                    DELAY_HIGH:   prog_period = cfg.step_period_high;
                    default:      prog_period = '0;
                endcase
                // Invalid delay choice drops the whole program beat.
                if (item.delay_choice != 2'(3)) begin
                    ptr_next = (ptr_reg == SLOT_W'(PATTERN_SLOTS - 1)) ? '0
                               : ptr_reg + SLOT_W'(1);
                    slot_steps_next[ptr_reg]  = item.pattern_steps;
                    slot_len_next[ptr_reg]    = len_sat;
                    slot_period_next[ptr_reg] = prog_period;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg      <= '0;
            seen_reg      <= 1'b0;
            change_reg    <= '0;
            handled_reg   <= 1'b0;
            mode_reg      <= MODE_FIXED;
            idx_reg       <= '0;
            step_last_reg <= '0;
            ptr_reg       <= '0;
            lamps_reg     <= LAMP_OFF;
            for (int b = 0; b < BLINK_MODES; b++) begin
                phase_reg[b]      <= 1'b0;
                blink_last_reg[b] <= '0;
            end
            for (int s = 0; s < PATTERN_SLOTS; s++) begin
                slot_steps_reg[s]  <= '0;
                slot_len_reg[s]    <= '0;
                slot_period_reg[s] <= '0;
            end
        end else if (fire) begin
            time_reg        <= time_next;
            seen_reg        <= seen_next;
            change_reg      <= change_next;
            handled_reg     <= handled_next;
            mode_reg        <= mode_next;
            idx_reg         <= idx_next;
            step_last_reg   <= step_last_next;
            ptr_reg         <= ptr_next;
            lamps_reg       <= lamps_next;
            phase_reg       <= phase_next;
            blink_last_reg  <= blink_last_next;
            slot_steps_reg  <= slot_steps_next;
            slot_len_reg    <= slot_len_next;
            slot_period_reg <= slot_period_next;
        end
    end

    assign res.lamps = lamps_next;
    assign res.mode  = mode_next;

endmodule

// ===== rtl/core/button_led_pattern_sequencer.sv =====
`timescale 1ns / 1ps
// Lamp pattern sequencer top level: input register, sequencer core, result register.
// An accepted input beat is held in the input register, then in the result register, and shows on m_tvalid/m_tdata.
// Throughput: 1 beat per cycle while m_tready stays high; each beat is one short combinational pass of the core.
// Reset (aresetn low, synchronous): both stages empty, registers to defaults,
// time base, mode, blink and step state and all pattern slots cleared (slots empty).
// Depends on blps_pkg, blps_cfg_regs and blps_core.
module button_led_pattern_sequencer
    import blps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] button_level, [3:1] new_mode, [21:4] pattern_steps,
    // [25:22] pattern_length, [27:26] delay_choice, [31:28] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [IN_USER_W-1:0]  s_tuser,

    // Result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] lamp_red, [1] lamp_yellow, [2] lamp_green, [5:3] mode_now, [7:6] zero
    output logic [OUT_DATA_W-1:0] m_tdata,

    // Register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PERIOD_W-1:0]   cfg_data
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    s_fire;
    logic    advance;
    cfg_t    cfg;
    result_t core_res;

    // Register writes are always taken; the register file absorbs one per cycle.
    assign cfg_ready = 1'b1;

    blps_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held beat into the result register when that register is
    // empty or being drained this cycle. The input register refills in the
    // same cycle; while the result stalls, one more beat can land in the
    // input register and then s_tready drops until the result drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat; unpack tdata/tuser into the item fields.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.kind           <= s_tuser[1:0];
            in_item_reg.button_level   <= s_tdata[0];
            in_item_reg.new_mode       <= s_tdata[3:1];
            in_item_reg.pattern_steps  <= s_tdata[21:4];
            in_item_reg.pattern_length <= s_tdata[25:22];
            in_item_reg.delay_choice   <= s_tdata[27:26];
        end
    end

    blps_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    // Result register mirrors the core's lamps and mode after every beat;
    // reset value matches the core's reset state (lamps off, mode 0).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_res_reg <= '0;
        end else if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.mode, out_res_reg.lamps[0],
                       out_res_reg.lamps[1], out_res_reg.lamps[2]};

`ifndef SYNTHESIS
    // A set beat shows the forced mode in its result.
    a_set_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.kind == KIND_SET |=> m_tdata[5:3] == $past(in_item_reg.new_mode))
        else $error("set beat did not force the mode");

    // A tick that lands in mode 0 always lights yellow and green only.
    a_mode0_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.kind == KIND_TICK && core_res.mode == MODE_FIXED
        |=> m_tdata[2:0] == 3'b110)
        else $error("mode 0 lamps wrong");

    // Program beats and unknown kinds leave lamps and mode as they were.
    a_program_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.kind != KIND_TICK && in_item_reg.kind != KIND_SET
        |=> m_tdata[5:0] == $past(m_tdata[5:0]))
        else $error("command beat changed lamps or mode");
`endif

endmodule
